FILE: design/awcd_pkg.sv
package awcd_pkg;

  localparam int CHAN_W         = 8;
  localparam int COLOUR_SUM_W   = 22;
  localparam int WEIGHT_SUM_W   = 15;
  localparam int COVERAGE_SUM_W = 14;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = 2;

  // sums of one finished cell, handed from the accumulator to the divider
  typedef struct packed {
    logic [COLOUR_SUM_W-1:0]   red_sum;
    logic [COLOUR_SUM_W-1:0]   green_sum;
    logic [COLOUR_SUM_W-1:0]   blue_sum;
    logic [WEIGHT_SUM_W-1:0]   weight_sum;
    logic [COVERAGE_SUM_W-1:0] coverage_sum;
  } cell_sums_t;

  // write side of the cell queue
  typedef struct packed {
    logic       push;
    cell_sums_t data;
  } queue_wr_t;

  // read side of the cell queue
  typedef struct packed {
    logic       empty;
    cell_sums_t data;
  } queue_rd_t;

endpackage

FILE: design/awcd_front.sv
module awcd_front
  import awcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // brick_colour
  input  logic        s_tlast,   // last_in_cell
  input  logic        queue_full,
  output queue_wr_t   queue_wr
);

  logic [COLOUR_SUM_W-1:0]   red_sum, green_sum, blue_sum;
  logic [WEIGHT_SUM_W-1:0]   weight_sum;
  logic [COVERAGE_SUM_W-1:0] coverage_sum;

  logic                      occupied;
  logic [CHAN_W-1:0]         alpha;
  logic [CHAN_W:0]           weight;
  logic [2*CHAN_W:0]         red_prod, green_prod, blue_prod;
  logic [COLOUR_SUM_W:0]     red_raw, green_raw, blue_raw;
  logic [WEIGHT_SUM_W:0]     weight_raw;
  logic [COVERAGE_SUM_W:0]   coverage_raw;
  cell_sums_t                acc;
  logic                      accept;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  assign occupied = (s_tdata != 32'd0);
  assign alpha    = s_tdata[31:24];
  assign weight   = {1'b0, alpha} + 9'd1;

  assign red_prod   = 17'(s_tdata[7:0]) * 17'(weight);
  assign green_prod = 17'(s_tdata[15:8]) * 17'(weight);
  assign blue_prod  = 17'(s_tdata[23:16]) * 17'(weight);

  always_comb begin
    red_raw      = {1'b0, red_sum};
    green_raw    = {1'b0, green_sum};
    blue_raw     = {1'b0, blue_sum};
    weight_raw   = {1'b0, weight_sum};
    coverage_raw = {1'b0, coverage_sum};
    if (occupied) begin
      red_raw      = red_raw + 23'(red_prod);
      green_raw    = green_raw + 23'(green_prod);
      blue_raw     = blue_raw + 23'(blue_prod);
      weight_raw   = weight_raw + 16'(weight);
      coverage_raw = coverage_raw + 15'(alpha);
    end
    // saturate at the top of each width
    acc.red_sum      = red_raw[COLOUR_SUM_W] ? '1 : red_raw[COLOUR_SUM_W-1:0];
    acc.green_sum    = green_raw[COLOUR_SUM_W] ? '1 : green_raw[COLOUR_SUM_W-1:0];
    acc.blue_sum     = blue_raw[COLOUR_SUM_W] ? '1 : blue_raw[COLOUR_SUM_W-1:0];
    acc.weight_sum   = weight_raw[WEIGHT_SUM_W] ? '1 : weight_raw[WEIGHT_SUM_W-1:0];
    acc.coverage_sum = coverage_raw[COVERAGE_SUM_W] ? '1
                                                    : coverage_raw[COVERAGE_SUM_W-1:0];
  end

  assign queue_wr.push = accept && s_tlast;
  assign queue_wr.data = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_sum      <= '0;
      green_sum    <= '0;
      blue_sum     <= '0;
      weight_sum   <= '0;
      coverage_sum <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        red_sum      <= '0;
        green_sum    <= '0;
        blue_sum     <= '0;
        weight_sum   <= '0;
        coverage_sum <= '0;
      end else begin
        red_sum      <= acc.red_sum;
        green_sum    <= acc.green_sum;
        blue_sum     <= acc.blue_sum;
        weight_sum   <= acc.weight_sum;
        coverage_sum <= acc.coverage_sum;
      end
    end
  end

endmodule

FILE: design/awcd_queue.sv
module awcd_queue
  import awcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  queue_wr_t queue_wr,
  output logic      queue_full,
  input  logic      pop,
  output queue_rd_t queue_rd
);

  cell_sums_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push, do_pop;

  assign queue_full     = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign queue_rd.empty = (count == '0);
  assign queue_rd.data  = entries[rd_ptr];

  assign do_push = queue_wr.push && !queue_full;
  assign do_pop  = pop && !queue_rd.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= queue_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/awcd_back.sv
module awcd_back
  import awcd_pkg::*;
#(
  parameter int BRICKS_PER_CELL = 64
)
(
  input  logic        clk,
  input  logic        rst,
  input  queue_rd_t   queue_rd,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_colour
  output logic        m_tuser    // cell_occupied
);

  localparam int              DIV_STEPS   = COLOUR_SUM_W;
  localparam int              STEP_W      = $clog2(DIV_STEPS);
  localparam int              REM_W       = WEIGHT_SUM_W;
  // floor(coverage * recip >> shift) is exact for 14-bit coverage up to 512 bricks
  localparam int              RECIP_SHIFT = 23;
  localparam int              RECIP_W     = RECIP_SHIFT + 1;
  localparam int              PROD_W      = COVERAGE_SUM_W + RECIP_W;
  localparam int              QUO_W       = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] ALPHA_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + BRICKS_PER_CELL - 1) / BRICKS_PER_CELL);

  typedef enum logic [1:0] {IDLE, DIVIDE, EMIT} state_t;

  state_t                  state;
  logic [STEP_W-1:0]       step_cnt;
  logic [WEIGHT_SUM_W-1:0] divisor;
  logic [COVERAGE_SUM_W-1:0] coverage;
  logic [COLOUR_SUM_W-1:0] red_num, green_num, blue_num;
  logic [REM_W-1:0]        red_rem, green_rem, blue_rem;
  logic [REM_W+COLOUR_SUM_W-1:0] red_nx, green_nx, blue_nx;
  logic [PROD_W-1:0]       alpha_prod;
  logic [QUO_W-1:0]        alpha_quo;
  logic [CHAN_W-1:0]       red_q, green_q, blue_q, alpha_q, alpha_out;

  // one restoring step: quotient bits shift into the numerator register
  function automatic logic [REM_W+COLOUR_SUM_W-1:0] div_step(
    input logic [REM_W-1:0]        rem,
    input logic [COLOUR_SUM_W-1:0] num,
    input logic [REM_W:0]          dvs
  );
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    trial = {rem, num[COLOUR_SUM_W-1]};
    diff  = trial - dvs;
    if (trial >= dvs) begin
      return {diff[REM_W-1:0], num[COLOUR_SUM_W-2:0], 1'b1};
    end
    return {trial[REM_W-1:0], num[COLOUR_SUM_W-2:0], 1'b0};
  endfunction

  function automatic logic [CHAN_W-1:0] clamp(input logic [COLOUR_SUM_W-1:0] q);
    return (q[COLOUR_SUM_W-1:CHAN_W] != '0) ? '1 : q[CHAN_W-1:0];
  endfunction

  assign pop = (state == IDLE) && !queue_rd.empty;

  assign red_nx   = div_step(red_rem, red_num, {1'b0, divisor});
  assign green_nx = div_step(green_rem, green_num, {1'b0, divisor});
  assign blue_nx  = div_step(blue_rem, blue_num, {1'b0, divisor});

  // coverage divided by the bricks per cell through a constant reciprocal
  assign alpha_prod = PROD_W'(coverage) * PROD_W'(ALPHA_RECIP);
  assign alpha_quo  = alpha_prod[PROD_W-1:RECIP_SHIFT];

  assign red_q     = clamp(red_num);
  assign green_q   = clamp(green_num);
  assign blue_q    = clamp(blue_num);
  assign alpha_q   = (alpha_quo[QUO_W-1:CHAN_W] != '0) ? '1 : alpha_quo[CHAN_W-1:0];
  assign alpha_out = (alpha_q == '0) ? CHAN_W'(1) : alpha_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (pop) begin
            divisor   <= queue_rd.data.weight_sum;
            red_num   <= queue_rd.data.red_sum;
            green_num <= queue_rd.data.green_sum;
            blue_num  <= queue_rd.data.blue_sum;
            coverage  <= queue_rd.data.coverage_sum;
            red_rem   <= '0;
            green_rem <= '0;
            blue_rem  <= '0;
            step_cnt  <= '0;
            state     <= DIVIDE;
          end
        end
        DIVIDE: begin
          {red_rem, red_num}     <= red_nx;
          {green_rem, green_num} <= green_nx;
          {blue_rem, blue_num}   <= blue_nx;
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(DIV_STEPS-1)) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (divisor == '0) begin
              m_tdata <= '0;
              m_tuser <= 1'b0;
            end else begin
              m_tdata <= {alpha_out, blue_q, green_q, red_q};
              m_tuser <= 1'b1;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: design/alpha_weighted_colour_downsample.sv
// alpha weighted colour downsample: takes one packed rgba brick word per cycle
// while the queue has room and, on the word marked last of its cell, produces
// one averaged cell word. the accumulator takes a brick every cycle unless the
// queue is full; finished cell sums wait in the four-entry queue for the
// divider (a 22-step restoring divide run in parallel for the three colour
// channels against the shared weight sum, while the coverage is divided by
// the parameter BRICKS_PER_CELL with a constant reciprocal multiply). with the
// output not stalled, cells with as many bricks as the divider spends cycles
// on a cell, or more, stream at one brick per cycle; shorter cells are paced
// by the divider once the queue fills. sums saturate at their widths.
module alpha_weighted_colour_downsample
  import awcd_pkg::*;
#(
  parameter int BRICKS_PER_CELL = 64   // 1 to 512, divisor for the alpha
)
(
  input  logic        clk,
  input  logic        rst,
  // brick request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // brick_colour
  input  logic        s_tlast,   // last_in_cell
  // cell result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_colour
  output logic        m_tuser    // cell_occupied
);

  // front to queue
  queue_wr_t queue_wr;
  logic      queue_full;
  // queue to back
  queue_rd_t queue_rd;
  logic      pop;

  // accumulator: weighted sums over the bricks of the current cell
  awcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (queue_full),
    .queue_wr   (queue_wr)
  );

  // finished cell sums waiting for the divider
  awcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .queue_wr   (queue_wr),
    .queue_full (queue_full),
    .pop        (pop),
    .queue_rd   (queue_rd)
  );

  // divider and output register
  awcd_back #(
    .BRICKS_PER_CELL (BRICKS_PER_CELL)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .queue_rd (queue_rd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
